FILE: rtl/eatrm_pkg.sv
package eatrm_pkg;

  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int ELEMENT_WIDTH_DEF = 16;

  localparam logic [31:0] Q30_ONE        = 32'd1073741824;
  localparam logic [31:0] Q30_PI         = 32'd3373259426;
  localparam logic [31:0] Q30_HALF_PI    = 32'd1686629713;
  localparam logic [31:0] Q30_QUARTER_PI = 32'd843314857;

  localparam logic [2:0] ORD_XYZ = 3'd0;
  localparam logic [2:0] ORD_ZYX = 3'd1;
  localparam logic [2:0] ORD_YZX = 3'd2;
  localparam logic [2:0] ORD_XZY = 3'd3;
  localparam logic [2:0] ORD_YXZ = 3'd4;
  localparam logic [2:0] ORD_ZXY = 3'd5;

  // Q30 signed matrix element, range within +-2^30
  typedef logic signed [31:0] q30_t;
  typedef q30_t mat_t [9];

  // Q30 * Q30 product, rounded to nearest, ties away from zero
  function automatic q30_t round60(input logic signed [65:0] acc);
    logic [65:0] mag;
    logic [65:0] r;
    begin
      mag = acc[65] ? 66'(-acc) : 66'(acc);
      r = (mag + 66'(Q30_ONE >> 1)) >> 30;
      round60 = acc[65] ? 32'(-r) : 32'(r);
    end
  endfunction

endpackage

FILE: rtl/eatrm_sincos.sv
// Pipelined fixed-point sine/cosine: reduction, then one Horner term per two stages.
module eatrm_sincos #(
  parameter int ANGLE_WIDTH = eatrm_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ANGLE_WIDTH-1:0] angle,
  output eatrm_pkg::q30_t        sin_q,
  output eatrm_pkg::q30_t        cos_q
);
  import eatrm_pkg::*;

  localparam int NT  = 6;
  localparam int NST = 2 * NT + 1;
  localparam int SHL = 30 - (ANGLE_WIDTH - 3);

  logic [33:0] mag;
  logic [33:0] m;
  logic [31:0] t_c;
  logic        neg;
  logic        sneg_c;
  logic        cneg_c;

  always_comb begin
    neg = angle[ANGLE_WIDTH-1];
    mag = neg ? 34'((35'(1) << ANGLE_WIDTH) - 35'(angle)) : 34'(angle);
    m = (SHL >= 0) ? (mag << SHL) : (mag >> (-SHL));
    sneg_c = neg;
    cneg_c = 1'b0;
    if (m <= 34'(Q30_HALF_PI)) begin
      t_c = 32'(m);
    end else if (m <= 34'(Q30_PI)) begin
      t_c = 32'(34'(Q30_PI) - m);
      cneg_c = 1'b1;
    end else begin
      t_c = 32'(m - 34'(Q30_PI));
      cneg_c = 1'b1;
      sneg_c = ~neg;
    end
  end

  // stage 0: reduced angle
  logic [30:0] u0;
  logic        sw0, sn0, cn0;
  always_ff @(posedge clk) begin
    if (en) begin
      sw0 <= t_c > Q30_QUARTER_PI;
      u0  <= (t_c > Q30_QUARTER_PI) ? 31'(Q30_HALF_PI - t_c) : 31'(t_c);
      sn0 <= sneg_c;
      cn0 <= cneg_c;
    end
  end

  // stage 1: u squared
  logic [30:0] u1, u2;
  logic        sw1, sn1, cn1;
  logic [61:0] usq;
  assign usq = u0 * u0;
  always_ff @(posedge clk) begin
    if (en) begin
      u1 <= u0; u2 <= 31'(usq >> 30);
      sw1 <= sw0; sn1 <= sn0; cn1 <= cn0;
    end
  end

  // Horner terms 0..5, two stages each; sine uses 5 terms, cosine 6
  logic [30:0] hu   [NST];
  logic [30:0] hu2  [2*NT-1];
  logic        hsw  [NST];
  logic        hsn  [NST];
  logic        hcn  [NST];
  logic [30:0] ts   [NT+1];
  logic [30:0] tc   [NT+1];
  logic [30:0] qs   [NT];
  logic [30:0] qc   [NT];

  localparam logic [7:0] SDIV [6] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
  localparam logic [7:0] CDIV [6] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};

  assign hu[0] = u1; assign hu2[0] = u2;
  assign ts[0] = 31'(Q30_ONE); assign tc[0] = 31'(Q30_ONE);
  assign hsw[0] = sw1; assign hsn[0] = sn1; assign hcn[0] = cn1;

  for (genvar s = 0; s < NST - 1; s++) begin : g_pass
    always_ff @(posedge clk) begin
      if (en) begin
        hu[s+1] <= hu[s];
        hsw[s+1] <= hsw[s]; hsn[s+1] <= hsn[s]; hcn[s+1] <= hcn[s];
      end
    end
  end

  for (genvar s = 0; s < 2 * NT - 2; s++) begin : g_pass_sq
    always_ff @(posedge clk) begin
      if (en) hu2[s+1] <= hu2[s];
    end
  end

  for (genvar g = 0; g < NT; g++) begin : g_h
    // reciprocal multiply, exact for dividends below 2^31
    localparam int SSH = 31 + $clog2(SDIV[g]);
    localparam int CSH = 31 + $clog2(CDIV[g]);
    localparam logic [31:0] SMUL =
      32'(((64'd1 << SSH) + 64'(SDIV[g]) - 64'd1) / 64'(SDIV[g]));
    localparam logic [31:0] CMUL =
      32'(((64'd1 << CSH) + 64'(CDIV[g]) - 64'd1) / 64'(CDIV[g]));
    logic [61:0] ps_w, pc_w;
    logic [62:0] qs_w, qc_w;
    assign ps_w = hu2[2*g] * ts[g];
    assign pc_w = hu2[2*g] * tc[g];
    assign qs_w = qs[g] * SMUL;
    assign qc_w = qc[g] * CMUL;
    // scale by u squared; hold the finished sine term
    always_ff @(posedge clk) begin
      if (en) begin
        qs[g] <= (g < NT - 1) ? 31'(ps_w >> 30) : ts[g];
        qc[g] <= 31'(pc_w >> 30);
      end
    end
    // divide by the series constant and subtract from one; the finished sine term passes on
    always_ff @(posedge clk) begin
      if (en) begin
        ts[g+1] <= (g < NT - 1) ? 31'(Q30_ONE - 32'(qs_w >> SSH)) : qs[g];
        tc[g+1] <= 31'(Q30_ONE - 32'(qc_w >> CSH));
      end
    end
  end

  // final: sine product, swap, signs
  logic [61:0] sp;
  logic [31:0] ps, sv, cv;
  always_comb begin
    sp = hu[NST-1] * ts[NT];
    ps = 32'(sp >> 30);
    sv = hsw[NST-1] ? 32'(tc[NT]) : ps;
    cv = hsw[NST-1] ? ps : 32'(tc[NT]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= hsn[NST-1] ? -$signed(sv) : $signed(sv);
      cos_q <= hcn[NST-1] ? -$signed(cv) : $signed(cv);
    end
  end
endmodule

FILE: rtl/eatrm_mul3.sv
// Registered 3x3 Q30 matrix product with rounding.
module eatrm_mul3 (
  input  logic            clk,
  input  logic            en,
  input  eatrm_pkg::mat_t a,
  input  eatrm_pkg::mat_t b,
  output eatrm_pkg::mat_t r
);
  import eatrm_pkg::*;

  logic signed [63:0] p [27];
  for (genvar i = 0; i < 3; i++) begin : g_i
    for (genvar j = 0; j < 3; j++) begin : g_j
      for (genvar k = 0; k < 3; k++) begin : g_k
        always_ff @(posedge clk) begin
          if (en) p[i*9+j*3+k] <= 64'(a[i*3+k]) * 64'(b[k*3+j]);
        end
      end
      always_ff @(posedge clk) begin
        if (en) r[i*3+j] <= round60(66'(p[i*9+j*3]) + 66'(p[i*9+j*3+1]) + 66'(p[i*9+j*3+2]));
      end
    end
  end
endmodule

FILE: rtl/euler_angles_to_rotation_matrix.sv
// Euler angles to rotation matrix. Takes angle_x/y/z (signed radians, ANGLE_WIDTH-3
// fraction bits) and returns the nine elements of R, row-major, signed with
// ELEMENT_WIDTH-2 fraction bits, saturated to +-1. rotation_order picks the product:
// 0 XYZ=Rz*Ry*Rx, 1 ZYX=Rx*Ry*Rz, 2 YZX=Rx*Rz*Ry, 3 XZY=Ry*Rz*Rx, 4 YXZ=Rz*Rx*Ry,
// 5 ZXY=Ry*Rx*Rz; 6 and 7 give an all-zero matrix. One transaction per cycle is
// accepted while the output is not stalled. Path: sine/cosine stages (reduction,
// square, six Horner terms of two stages each, sine product), two 3x3 matrix products
// (partial products, then rounded sums), then output rounding. The whole pipeline advances
// together and holds when the output is stalled; rotation_order is sampled with each transaction.
module euler_angles_to_rotation_matrix #(
  parameter int ANGLE_WIDTH   = eatrm_pkg::ANGLE_WIDTH_DEF,
  parameter int ELEMENT_WIDTH = eatrm_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [2:0]                      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ANGLE_WIDTH-1:0]   angle_x,
  input  logic signed [ANGLE_WIDTH-1:0]   angle_y,
  input  logic signed [ANGLE_WIDTH-1:0]   angle_z,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ELEMENT_WIDTH-1:0] m00,
  output logic signed [ELEMENT_WIDTH-1:0] m01,
  output logic signed [ELEMENT_WIDTH-1:0] m02,
  output logic signed [ELEMENT_WIDTH-1:0] m10,
  output logic signed [ELEMENT_WIDTH-1:0] m11,
  output logic signed [ELEMENT_WIDTH-1:0] m12,
  output logic signed [ELEMENT_WIDTH-1:0] m20,
  output logic signed [ELEMENT_WIDTH-1:0] m21,
  output logic signed [ELEMENT_WIDTH-1:0] m22
);
  import eatrm_pkg::*;

  localparam int SC_LAT = 15;
  localparam int LAT    = SC_LAT + 5;
  localparam int RSH    = 30 - (ELEMENT_WIDTH - 2);

  logic [2:0] rotation_order;
  always_ff @(posedge clk) begin
    if (rst) rotation_order <= ORD_XYZ;
    else if (cfg_we) rotation_order <= cfg_wdata;
  end

  // global enable: advance whenever the output slot is free or being drained
  logic en;
  logic [LAT-1:0] vld;
  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  // order travels alongside the sine/cosine pipeline
  logic [2:0] ord_d [SC_LAT+1];
  assign ord_d[0] = rotation_order;
  for (genvar g = 0; g < SC_LAT; g++) begin : g_ord
    always_ff @(posedge clk) if (en) ord_d[g+1] <= ord_d[g];
  end

  q30_t sx, cx, sy, cy, sz, cz;
  eatrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sx (.clk, .en, .angle(angle_x), .sin_q(sx), .cos_q(cx));
  eatrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sy (.clk, .en, .angle(angle_y), .sin_q(sy), .cos_q(cy));
  eatrm_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sz (.clk, .en, .angle(angle_z), .sin_q(sz), .cos_q(cz));

  mat_t rx, ry, rz, ma, mb, mc;
  q30_t one;
  assign one = $signed(Q30_ONE);
  assign rx = '{one, 0, 0, 0, cx, -sx, 0, sx, cx};
  assign ry = '{cy, 0, sy, 0, one, 0, -sy, 0, cy};
  assign rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, one};

  logic [2:0] ord_s;
  assign ord_s = ord_d[SC_LAT];
  always_comb begin
    unique case (ord_s)
      ORD_XYZ: begin ma = rz; mb = ry; mc = rx; end
      ORD_ZYX: begin ma = rx; mb = ry; mc = rz; end
      ORD_YZX: begin ma = rx; mb = rz; mc = ry; end
      ORD_XZY: begin ma = ry; mb = rz; mc = rx; end
      ORD_YXZ: begin ma = rz; mb = rx; mc = ry; end
      ORD_ZXY: begin ma = ry; mb = rx; mc = rz; end
      default: begin ma = rz; mb = ry; mc = rx; end
    endcase
  end

  // hold the third factor for the second product, and the zero flag for the output stage
  mat_t mc1, mc2, ab, r;
  logic z1, z2, z3, z4;
  always_ff @(posedge clk) begin
    if (en) begin
      mc1 <= mc; mc2 <= mc1;
      z1 <= ord_s > ORD_ZXY; z2 <= z1; z3 <= z2; z4 <= z3;
    end
  end

  eatrm_mul3 u_m1 (.clk, .en, .a(ma), .b(mb), .r(ab));
  eatrm_mul3 u_m2 (.clk, .en, .a(ab), .b(mc2), .r(r));

  logic signed [ELEMENT_WIDTH-1:0] e [9];
  for (genvar g = 0; g < 9; g++) begin : g_out
    logic [31:0] mg, rm;
    logic signed [33:0] sv;
    always_comb begin
      mg = r[g][31] ? 32'(-r[g]) : 32'(r[g]);
      rm = (RSH > 0) ? ((mg + (32'd1 << (RSH - 1))) >> RSH) : mg;
      if (rm > (32'd1 << (ELEMENT_WIDTH - 2))) rm = 32'd1 << (ELEMENT_WIDTH - 2);
      sv = r[g][31] ? -$signed(34'(rm)) : $signed(34'(rm));
    end
    always_ff @(posedge clk) begin
      if (en) e[g] <= z4 ? '0 : ELEMENT_WIDTH'(sv);
    end
  end

  assign m00 = e[0]; assign m01 = e[1]; assign m02 = e[2];
  assign m10 = e[3]; assign m11 = e[4]; assign m12 = e[5];
  assign m20 = e[6]; assign m21 = e[7]; assign m22 = e[8];
endmodule

FILE: rtl/eatrm_checker.sv
module eatrm_checker #(
  parameter int ELEMENT_WIDTH = eatrm_pkg::ELEMENT_WIDTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [ELEMENT_WIDTH-1:0] m00,
  input logic signed [ELEMENT_WIDTH-1:0] m11
);
  localparam logic signed [ELEMENT_WIDTH-1:0] LIM = ELEMENT_WIDTH'(1 <<< (ELEMENT_WIDTH - 2));

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m00))
    else $error("output changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while output empty");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input valid dropped before acceptance");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> m00 <= LIM && m00 >= -LIM && m11 <= LIM && m11 >= -LIM)
    else $error("element beyond +-1");
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("valid after reset");
endmodule

bind euler_angles_to_rotation_matrix eatrm_checker #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .m00, .m11);
